>>> hdl/mtc_pkg.sv
// ---------------------------------------------------------------------------
// mtc_pkg: shared types and constants for the 4x4 matrix transform block
// Field widths, command codes, pipeline side-band and lane control types.
// ---------------------------------------------------------------------------
package mtc_pkg;

    localparam int FIELD_W        = 32;
    localparam int CMD_W          = 2;
    localparam int SLOT_W         = 4;
    localparam int MAT_DIM        = 4;
    localparam int MAT_SIZE       = MAT_DIM * MAT_DIM;
    localparam int COL_W          = $clog2(MAT_DIM);
    localparam int PROD_W         = 2 * FIELD_W;
    localparam int PAIR_W         = PROD_W + 1;
    localparam int SUM_W          = PROD_W + 2;

    localparam int DEF_FRAC_BITS  = 16;
    localparam int DEF_DATA_WIDTH = 32;

    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(MAT_DIM - 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAT_DIM - 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD    = 2'd0,
        CMD_XFORM   = 2'd1,
        CMD_COMPOSE = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    // stage advance strobes handed to every lane
    typedef struct packed {
        logic adv1;
        logic adv2;
    } lane_ctrl_t;

    // what travels alongside a request through the product pipeline
    typedef struct packed {
        logic             compose;
        logic [COL_W-1:0] col;
    } pipe_info_t;

    // results and stored elements saturate to the data width, at most the field
    function automatic int sat_width(input int data_width);
        return (data_width < FIELD_W) ? data_width : FIELD_W;
    endfunction

endpackage

>>> hdl/mtc_if.sv
// ---------------------------------------------------------------------------
// mtc_if: request and result channels of the matrix transform block
// Valid/ready handshake; a transfer happens when both are high at a clock edge.
// ---------------------------------------------------------------------------
interface mtc_req_if;
    import mtc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          cmd;
    logic [SLOT_W-1:0]         slot;
    logic signed [FIELD_W-1:0] load_value;
    logic signed [FIELD_W-1:0] in_x;
    logic signed [FIELD_W-1:0] in_y;
    logic signed [FIELD_W-1:0] in_z;
    logic signed [FIELD_W-1:0] in_w;

    modport source (
        output valid, cmd, slot, load_value, in_x, in_y, in_z, in_w,
        input  ready
    );

    modport sink (
        input  valid, cmd, slot, load_value, in_x, in_y, in_z, in_w,
        output ready
    );
endinterface

interface mtc_res_if;
    import mtc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] out_x;
    logic signed [FIELD_W-1:0] out_y;
    logic signed [FIELD_W-1:0] out_z;
    logic signed [FIELD_W-1:0] out_w;

    modport source (
        output valid, out_x, out_y, out_z, out_w,
        input  ready
    );

    modport sink (
        input  valid, out_x, out_y, out_z, out_w,
        output ready
    );
endinterface

>>> hdl/mtc_lane.sv
// ---------------------------------------------------------------------------
// mtc_lane: one matrix row times the input vector
// Four multipliers, a registered pair sum, then final add, shift and saturate.
// ---------------------------------------------------------------------------
module mtc_lane #(
    parameter int FRAC_BITS  = mtc_pkg::DEF_FRAC_BITS,
    parameter int DATA_WIDTH = mtc_pkg::DEF_DATA_WIDTH
) (
    input  logic                               clk,
    input  logic signed [mtc_pkg::FIELD_W-1:0] row_elem [mtc_pkg::MAT_DIM],
    input  logic signed [mtc_pkg::FIELD_W-1:0] vec      [mtc_pkg::MAT_DIM],
    input  mtc_pkg::lane_ctrl_t                ctrl,
    output logic signed [mtc_pkg::FIELD_W-1:0] dot
);
    import mtc_pkg::*;

    localparam int SAT_W = sat_width(DATA_WIDTH);
    localparam logic signed [SUM_W-1:0] SAT_MAX = (SUM_W'(1) << (SAT_W - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] SAT_MIN = ~SAT_MAX;

    logic signed [PROD_W-1:0] prod_reg [MAT_DIM];
    logic signed [PAIR_W-1:0] pair_reg [2];
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  shifted;
    logic signed [SUM_W-1:0]  clamped;

    always_ff @(posedge clk)
    begin
        if (ctrl.adv1)
        begin
            for (int k = 0; k < MAT_DIM; k++)
            begin
                prod_reg[k] <= row_elem[k] * vec[k];
            end
        end
        if (ctrl.adv2)
        begin
            pair_reg[0] <= PAIR_W'(prod_reg[0]) + PAIR_W'(prod_reg[1]);
            pair_reg[1] <= PAIR_W'(prod_reg[2]) + PAIR_W'(prod_reg[3]);
        end
    end

    // exact sum, floor shift, clamp to the data width
    always_comb
    begin
        sum     = SUM_W'(pair_reg[0]) + SUM_W'(pair_reg[1]);
        shifted = sum >>> FRAC_BITS;
        if (shifted > SAT_MAX)
            clamped = SAT_MAX;
        else if (shifted < SAT_MIN)
            clamped = SAT_MIN;
        else
            clamped = shifted;
    end

    assign dot = FIELD_W'(clamped);

endmodule

>>> hdl/matrix4_transform_compose_top.sv
// ---------------------------------------------------------------------------
// matrix4_transform_compose_top: 4x4 fixed-point matrix times vector
// Held matrix with element load, vector transform and column-wise compose.
// ---------------------------------------------------------------------------
// Takes one request per clock while ready is high, which back-pressure from the
// result side or a pending final compose column can drop, and passes each result
// through the product, pair-sum and output registers; the registered output lets
// intake continue while a result waits. Sixteen 32x32 multipliers (four row lanes
// of four) feed a registered pair sum and a final add/shift/saturate stage. Loads
// take effect for the very next request. The last compose column rewrites the
// held matrix when its result reaches the output register, so after that request
// ready stays low until then, also while the result side stalls.
module matrix4_transform_compose_top #(
    parameter int FRAC_BITS  = mtc_pkg::DEF_FRAC_BITS,
    parameter int DATA_WIDTH = mtc_pkg::DEF_DATA_WIDTH
) (
    input  logic      clk,
    input  logic      rst_n,
    mtc_req_if.sink   request,
    mtc_res_if.source result
);
    import mtc_pkg::*;

    localparam int SAT_W = sat_width(DATA_WIDTH);
    localparam logic signed [FIELD_W-1:0] LD_MAX =
        FIELD_W'((64'd1 << (SAT_W - 1)) - 64'd1);
    localparam logic signed [FIELD_W-1:0] LD_MIN = ~LD_MAX;
    localparam logic signed [FIELD_W-1:0] ONE_VAL =
        (FRAC_BITS <= SAT_W - 2) ? FIELD_W'(64'd1 << FRAC_BITS) : LD_MAX;

    logic signed [FIELD_W-1:0] held_reg [MAT_SIZE];
    logic signed [FIELD_W-1:0] pbuf_reg [MAT_SIZE];
    logic signed [FIELD_W-1:0] res_reg  [MAT_DIM];
    logic signed [FIELD_W-1:0] lane_dot [MAT_DIM];
    logic signed [FIELD_W-1:0] vec      [MAT_DIM];

    logic       s1_valid_reg, s1_valid_next;
    logic       s2_valid_reg, s2_valid_next;
    logic       out_valid_reg, out_valid_next;
    logic       hold_reg, hold_next;
    pipe_info_t s1_info_reg, s1_info_next;
    pipe_info_t s2_info_reg;

    lane_ctrl_t lane_ctrl;
    logic       adv_out;
    logic       accept;
    logic       is_load;
    logic       is_compose;
    logic       gives_result;
    logic       wb_col;
    logic       wb_last;
    logic signed [FIELD_W-1:0] load_sat;

    assign vec[0] = request.in_x;
    assign vec[1] = request.in_y;
    assign vec[2] = request.in_z;
    assign vec[3] = request.in_w;

    // stage advance: a stage moves when the next one is empty or moving
    always_comb
    begin
        adv_out        = !out_valid_reg || result.ready;
        lane_ctrl.adv2 = !s2_valid_reg || adv_out;
        lane_ctrl.adv1 = !s1_valid_reg || lane_ctrl.adv2;
    end

    assign request.ready = lane_ctrl.adv1 && !hold_reg;
    assign accept        = request.valid && request.ready;

    always_comb
    begin
        is_load      = (request.cmd == CMD_LOAD);
        is_compose   = (request.cmd == CMD_COMPOSE) && (request.slot < SLOT_W'(MAT_DIM));
        gives_result = (request.cmd == CMD_XFORM) || is_compose;

        s1_info_next.compose = is_compose;
        s1_info_next.col     = request.slot[COL_W-1:0];

        wb_col  = s2_valid_reg && adv_out && s2_info_reg.compose;
        wb_last = wb_col && (s2_info_reg.col == LAST_COL);

        s1_valid_next  = lane_ctrl.adv1 ? (accept && gives_result) : s1_valid_reg;
        s2_valid_next  = lane_ctrl.adv2 ? s1_valid_reg : s2_valid_reg;
        out_valid_next = adv_out ? s2_valid_reg : out_valid_reg;

        // final compose column blocks intake until the matrix is rewritten
        hold_next = hold_reg;
        if (accept && is_compose && (request.slot == LAST_SLOT))
            hold_next = 1'b1;
        else if (wb_last)
            hold_next = 1'b0;

        if (request.load_value > LD_MAX)
            load_sat = LD_MAX;
        else if (request.load_value < LD_MIN)
            load_sat = LD_MIN;
        else
            load_sat = request.load_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hold_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
            hold_reg      <= hold_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (lane_ctrl.adv1)
            s1_info_reg <= s1_info_next;
        if (lane_ctrl.adv2)
            s2_info_reg <= s1_info_reg;
        if (adv_out)
        begin
            for (int r = 0; r < MAT_DIM; r++)
            begin
                res_reg[r] <= lane_dot[r];
            end
        end
        if (wb_col)
        begin
            for (int r = 0; r < MAT_DIM; r++)
            begin
                pbuf_reg[{s2_info_reg.col, COL_W'(r)}] <= lane_dot[r];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAT_SIZE; i++)
            begin
                held_reg[i] <= ((i / MAT_DIM) == (i % MAT_DIM)) ? ONE_VAL : '0;
            end
        end
        else
        begin
            if (accept && is_load)
                held_reg[request.slot] <= load_sat;
            if (wb_last)
            begin
                for (int i = 0; i < MAT_SIZE - MAT_DIM; i++)
                begin
                    held_reg[i] <= pbuf_reg[i];
                end
                for (int r = 0; r < MAT_DIM; r++)
                begin
                    held_reg[MAT_SIZE - MAT_DIM + r] <= lane_dot[r];
                end
            end
        end
    end

    for (genvar r = 0; r < MAT_DIM; r++)
    begin : g_lane
        logic signed [FIELD_W-1:0] row_elem [MAT_DIM];

        for (genvar k = 0; k < MAT_DIM; k++)
        begin : g_tap
            assign row_elem[k] = held_reg[k * MAT_DIM + r];
        end

        mtc_lane #(
            .FRAC_BITS  (FRAC_BITS),
            .DATA_WIDTH (DATA_WIDTH)
        ) u_lane (
            .clk      (clk),
            .row_elem (row_elem),
            .vec      (vec),
            .ctrl     (lane_ctrl),
            .dot      (lane_dot[r])
        );
    end

    assign result.valid = out_valid_reg;
    assign result.out_x = res_reg[0];
    assign result.out_y = res_reg[1];
    assign result.out_z = res_reg[2];
    assign result.out_w = res_reg[3];

endmodule

>>> hdl/mtc_checker.sv
// ---------------------------------------------------------------------------
// mtc_checker: port-level checks for the matrix transform block
// Result hold under stall, compose-final intake block, quiet after reset.
// ---------------------------------------------------------------------------
module mtc_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               req_valid,
    input logic                               req_ready,
    input logic [mtc_pkg::CMD_W-1:0]          req_cmd,
    input logic [mtc_pkg::SLOT_W-1:0]         req_slot,
    input logic                               res_valid,
    input logic                               res_ready,
    input logic signed [mtc_pkg::FIELD_W-1:0] res_x,
    input logic signed [mtc_pkg::FIELD_W-1:0] res_y,
    input logic signed [mtc_pkg::FIELD_W-1:0] res_z,
    input logic signed [mtc_pkg::FIELD_W-1:0] res_w
);
    import mtc_pkg::*;

    // a stalled result stays put
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_x) && $stable(res_y)
            && $stable(res_z) && $stable(res_w))
        else $error("result changed while stalled");

    // the final compose column rewrites the matrix before the next request
    a_compose_block: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_cmd == CMD_COMPOSE) && (req_slot == LAST_SLOT)
            |=> !req_ready)
        else $error("request taken right after final compose column");

    // nothing comes out on the first edge after reset
    a_reset_quiet: assert property (@(posedge clk)
        $past(!rst_n) |-> !res_valid)
        else $error("result valid right after reset");

endmodule

bind matrix4_transform_compose_top mtc_checker u_mtc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .req_cmd   (request.cmd),
    .req_slot  (request.slot),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_x     (result.out_x),
    .res_y     (result.out_y),
    .res_z     (result.out_z),
    .res_w     (result.out_w)
);
